// ----- rtl/gemm_pkg.sv -----
// Shared definitions for the int8 matrix multiply block.
// Holds default sizes, command codes, register indexes and reset values, and the sweep struct.
// No dependencies.
package gemm_pkg;

  localparam int GEMM_MAX_N = 16;
  localparam int GEMM_MAX_K = 64;
  localparam int GEMM_MAX_M = 256;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [4:0] COLS_RESET  = 5'd16;
  localparam logic [6:0] DEPTH_RESET = 7'd64;
  localparam logic [8:0] ROWS_RESET  = 9'd256;

  localparam logic CMD_LOAD_B = 1'b0;
  localparam logic CMD_A_ELEM = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS  = 2'd0,
    CFG_DEPTH = 2'd1,
    CFG_ROWS  = 2'd2
  } gemm_cfg_idx_t;

  typedef struct packed {
    logic issue;
    logic emit;
    logic last_matrix;
  } gemm_sweep_t;

endpackage

// ----- rtl/gemm_b_store.sv -----
// B operand store: MAX_K rows of MAX_N signed bytes.
// Single-element writes, whole-row registered reads.
// Depends on gemm_pkg.
module gemm_b_store import gemm_pkg::*; #(
  parameter int MAX_N = GEMM_MAX_N,
  parameter int MAX_K = GEMM_MAX_K,
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1,
  localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
  input  logic               clk,
  input  logic               wr_en_i,
  input  logic [KW-1:0]      wr_row_i,
  input  logic [CW-1:0]      wr_col_i,
  input  logic [7:0]         wr_data_i,
  input  logic               rd_en_i,
  input  logic [KW-1:0]      rd_row_i,
  output logic [MAX_N*8-1:0] rd_data_o
);

  logic [MAX_N-1:0][7:0] mem [MAX_K];
  logic [MAX_N-1:0][7:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_row_i][wr_col_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_q_r <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_q_r;

endmodule

// ----- rtl/gemm_acc_row.sv -----
// Row accumulator memory with a three-stage read, multiply, add and write-back pipeline.
// One column per cycle; on the last inner index the sums are emitted and cleared.
// Depends on gemm_pkg.
module gemm_acc_row import gemm_pkg::*; #(
  parameter int MAX_N = GEMM_MAX_N,
  localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gemm_sweep_t        sweep_i,
  input  logic [CW-1:0]      col_i,
  input  logic signed [7:0]  value_i,
  input  logic [MAX_N*8-1:0] brow_i,
  input  logic [CW-1:0]      n_last_i,
  input  logic [7:0]         row_i,
  output logic               busy_o,
  output logic               out_valid_o,
  output logic [7:0]         out_row_o,
  output logic [3:0]         out_col_o,
  output logic signed [31:0] out_sum_o,
  output logic               out_last_of_row_o,
  output logic               out_last_of_matrix_o
);

  logic [31:0]       mem [MAX_N];
  logic [MAX_N-1:0]  acc_vld_r;

  logic              s1_vld_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_emit_r;
  logic              s1_lastm_r;
  logic [31:0]       acc_q_r;
  logic              acc_qv_r;

  logic              s2_vld_r;
  logic [CW-1:0]     s2_col_r;
  logic              s2_emit_r;
  logic              s2_lastm_r;
  logic signed [15:0] prod_r;
  logic [31:0]       acc_h_r;

  logic              out_valid_r;
  logic [7:0]        out_row_r;
  logic [3:0]        out_col_r;
  logic [31:0]       out_sum_r;
  logic              out_lr_r;
  logic              out_lm_r;

  logic signed [7:0]  b_sel;
  logic signed [15:0] prod;
  logic [31:0]        sum;

  assign b_sel = brow_i[s1_col_r*8 +: 8];
  assign prod  = value_i * b_sel;
  assign sum   = acc_h_r + {{16{prod_r[15]}}, prod_r};

  always_ff @(posedge clk) begin
    if (sweep_i.issue) begin
      acc_q_r <= mem[col_i];
    end
    if (s2_vld_r) begin
      mem[s2_col_r] <= s2_emit_r ? 32'd0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r   <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= sweep_i.issue;
      s2_vld_r    <= s1_vld_r;
      out_valid_r <= s2_vld_r && s2_emit_r;
      if (s2_vld_r) begin
        acc_vld_r[s2_col_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r   <= col_i;
    s1_emit_r  <= sweep_i.emit;
    s1_lastm_r <= sweep_i.last_matrix;
    acc_qv_r   <= acc_vld_r[col_i];

    s2_col_r   <= s1_col_r;
    s2_emit_r  <= s1_emit_r;
    s2_lastm_r <= s1_lastm_r;
    prod_r     <= prod;
    acc_h_r    <= acc_qv_r ? acc_q_r : 32'd0;

    out_row_r  <= row_i;
    out_col_r  <= 4'(s2_col_r);
    out_sum_r  <= sum;
    out_lr_r   <= (s2_col_r == n_last_i);
    out_lm_r   <= (s2_col_r == n_last_i) && s2_lastm_r;
  end

  assign busy_o               = s1_vld_r | s2_vld_r;
  assign out_valid_o          = out_valid_r;
  assign out_row_o            = out_row_r;
  assign out_col_o            = out_col_r;
  assign out_sum_o            = out_sum_r;
  assign out_last_of_row_o    = out_lr_r;
  assign out_last_of_matrix_o = out_lm_r;

endmodule

// ----- rtl/gemm_int8_int32_accumulate.sv -----
// Signed 8-bit matrix multiply with 32-bit wrapping accumulation, one row of C at a time.
// Top level: configuration registers, command decode, column sequencer and row counter.
// Depends on gemm_pkg, gemm_b_store and gemm_acc_row.
//
// Usage: a beat is taken on start while busy is low. cmd 0 writes one B element into
// the store. cmd 1 applies one A element a[i][p] to the row accumulators; the column
// sequencer walks the n columns, one per cycle, through the accumulator memory, so busy
// stays high while the item passes through. An A element whose inner index is not
// below k is dropped. When p is k - 1 the row is emitted: out_valid pulses once per
// column, in column order, one result each cycle, each passing the sequencer, the
// accumulator read, multiply and output registers. The receiver cannot stall; every
// result stands for exactly one cycle. Configuration writes through cfg_we, cfg_index
// and cfg_wdata take effect at once and belong to idle periods.
// Synchronous reset clears the accumulators (through per-column valid bits), the row
// counter and the sequencer, and sets n, k and m to their maxima; the B store keeps
// whatever it holds and must be loaded before use.
module gemm_int8_int32_accumulate import gemm_pkg::*; #(
  parameter int MAX_N = GEMM_MAX_N,
  parameter int MAX_K = GEMM_MAX_K,
  parameter int MAX_M = GEMM_MAX_M
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [5:0]            in_inner_index,
  input  logic [3:0]            in_col_index,
  input  logic signed [7:0]     in_value,
  output logic                  out_valid,
  output logic [7:0]            out_row,
  output logic [3:0]            out_col,
  output logic signed [31:0]    out_sum,
  output logic                  out_last_of_row,
  output logic                  out_last_of_matrix,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int RW  = (MAX_M > 1) ? $clog2(MAX_M) : 1;
  localparam int NCW = $clog2(MAX_N + 1);
  localparam int KCW = $clog2(MAX_K + 1);
  localparam int MCW = $clog2(MAX_M + 1);

  logic [4:0] cols_r;
  logic [6:0] depth_r;
  logic [8:0] rows_r;

  logic [NCW-1:0] n_eff;
  logic [KCW-1:0] k_eff;
  logic [MCW-1:0] m_eff;
  logic [CW-1:0]  n_last;

  logic           run_r;
  logic           run_nxt;
  logic [CW-1:0]  col_r;
  logic [CW-1:0]  col_nxt;
  logic           emit_r;
  logic           lastm_r;
  logic signed [7:0] value_r;
  logic [7:0]     row_out_r;
  logic [RW-1:0]  row_cnt_r;
  logic [RW-1:0]  row_cnt_nxt;

  logic           accept;
  logic           load_ok;
  logic           a_ok;
  logic           a_emit;
  logic           last_matrix;
  logic           acc_busy;
  logic [MAX_N*8-1:0] brow;
  gemm_sweep_t    sweep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= COLS_RESET;
      depth_r <= DEPTH_RESET;
      rows_r  <= ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS:  cols_r  <= cfg_wdata[4:0];
        CFG_DEPTH: depth_r <= cfg_wdata[6:0];
        CFG_ROWS:  rows_r  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (cols_r == '0) begin
      n_eff = NCW'(1);
    end else if (32'(cols_r) > 32'(MAX_N)) begin
      n_eff = NCW'(MAX_N);
    end else begin
      n_eff = NCW'(cols_r);
    end
    if (depth_r == '0) begin
      k_eff = KCW'(1);
    end else if (32'(depth_r) > 32'(MAX_K)) begin
      k_eff = KCW'(MAX_K);
    end else begin
      k_eff = KCW'(depth_r);
    end
    if (rows_r == '0) begin
      m_eff = MCW'(1);
    end else if (32'(rows_r) > 32'(MAX_M)) begin
      m_eff = MCW'(MAX_M);
    end else begin
      m_eff = MCW'(rows_r);
    end
  end

  assign n_last      = CW'(n_eff - NCW'(1));
  assign busy        = run_r | acc_busy;
  assign accept      = start && !busy;
  assign load_ok     = accept && (in_cmd == CMD_LOAD_B)
                       && (32'(in_inner_index) < 32'(MAX_K))
                       && (32'(in_col_index) < 32'(MAX_N));
  assign a_ok        = accept && (in_cmd == CMD_A_ELEM)
                       && (32'(in_inner_index) < 32'(k_eff));
  assign a_emit      = (32'(in_inner_index) == 32'(k_eff) - 32'd1);
  assign last_matrix = (32'(row_cnt_r) >= 32'(m_eff) - 32'd1);

  always_comb begin
    run_nxt     = run_r;
    col_nxt     = col_r;
    row_cnt_nxt = row_cnt_r;
    if (run_r) begin
      col_nxt = CW'(col_r + CW'(1));
      if (col_r == n_last) begin
        run_nxt = 1'b0;
      end
    end else if (a_ok) begin
      run_nxt = 1'b1;
      col_nxt = '0;
      if (a_emit) begin
        row_cnt_nxt = last_matrix ? '0 : RW'(row_cnt_r + RW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      col_r     <= '0;
      row_cnt_r <= '0;
    end else begin
      run_r     <= run_nxt;
      col_r     <= col_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ok) begin
      value_r   <= in_value;
      emit_r    <= a_emit;
      lastm_r   <= last_matrix;
      row_out_r <= 8'(row_cnt_r);
    end
  end

  assign sweep.issue       = run_r;
  assign sweep.emit        = emit_r;
  assign sweep.last_matrix = lastm_r;

  gemm_b_store #(
    .MAX_N (MAX_N),
    .MAX_K (MAX_K)
  ) u_b_store (
    .clk       (clk),
    .wr_en_i   (load_ok),
    .wr_row_i  (KW'(in_inner_index)),
    .wr_col_i  (CW'(in_col_index)),
    .wr_data_i (in_value),
    .rd_en_i   (a_ok),
    .rd_row_i  (KW'(in_inner_index)),
    .rd_data_o (brow)
  );

  gemm_acc_row #(
    .MAX_N (MAX_N)
  ) u_acc_row (
    .clk                  (clk),
    .rst_n                (rst_n),
    .sweep_i              (sweep),
    .col_i                (col_r),
    .value_i              (value_r),
    .brow_i               (brow),
    .n_last_i             (n_last),
    .row_i                (row_out_r),
    .busy_o               (acc_busy),
    .out_valid_o          (out_valid),
    .out_row_o            (out_row),
    .out_col_o            (out_col),
    .out_sum_o            (out_sum),
    .out_last_of_row_o    (out_last_of_row),
    .out_last_of_matrix_o (out_last_of_matrix)
  );

endmodule
